### design/mie_pkg.sv
// shared width constants and controller/datapath interface types for the modular inverse block
package mie_pkg;

    localparam int WIDTH    = 32;
    localparam int CNT_W    = $clog2(WIDTH);
    localparam int TDATA_W  = ((2 * WIDTH + 7) / 8) * 8;

    typedef logic [WIDTH-1:0] word_t;

    typedef struct packed {
        logic load;      // take a new beat into the remainder/coefficient registers
        logic div_init;  // set up a serial division of ra by rb
        logic div_step;  // one quotient bit
        logic update;    // advance the remainder and coefficient pairs
        logic capture;   // load the output register
    } mie_cmd_t;

    typedef struct packed {
        logic rb_zero;   // second remainder is zero, euclid is done
        logic cnt_last;  // final quotient bit this cycle
    } mie_status_t;

endpackage

### design/mie_datapath.sv
// datapath: remainder and coefficient registers, serial divider with fused quotient multiply
module mie_datapath (
    input  logic                  aclk,
    input  mie_pkg::mie_cmd_t     cmd,
    input  mie_pkg::word_t        modulus,
    input  mie_pkg::word_t        value,
    output mie_pkg::mie_status_t  status,
    output mie_pkg::word_t        gcd_result,
    output mie_pkg::word_t        inverse,
    output logic                  has_inverse
);
    import mie_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    word_t            m_reg, ra_reg, rb_reg, ma_reg, mb_reg;
    word_t            dvd_reg, acc_reg;
    logic [WIDTH:0]   rem_reg;
    logic             nega_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            gcd_reg, inv_reg;
    logic             has_reg;

    logic [WIDTH:0]   rem_sh;
    logic             ge;
    logic [WIDTH:0]   rem_next;
    word_t            acc_next;
    word_t            red;
    word_t            inv_next;

    always_comb begin
        rem_sh   = {rem_reg[WIDTH-1:0], dvd_reg[WIDTH-1]};
        ge       = rem_sh >= {1'b0, rb_reg};
        rem_next = ge ? (rem_sh - {1'b0, rb_reg}) : rem_sh;
        // horner accumulation of q * mb as quotient bits arrive msb first
        acc_next = {acc_reg[WIDTH-2:0], 1'b0} + (ge ? mb_reg : '0);
        // ma never exceeds m, so the reduction is a single compare
        red      = (ma_reg == m_reg) ? '0 : ma_reg;
        if (m_reg == '0) begin
            inv_next = '0;
        end else if (nega_reg && red != '0) begin
            inv_next = m_reg - red;
        end else begin
            inv_next = red;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= modulus;
            ra_reg   <= modulus;
            rb_reg   <= value;
            ma_reg   <= '0;
            mb_reg   <= WIDTH'(1);
            nega_reg <= 1'b1;
        end else if (cmd.update) begin
            ra_reg   <= rb_reg;
            rb_reg   <= rem_reg[WIDTH-1:0];
            ma_reg   <= mb_reg;
            mb_reg   <= acc_reg + ma_reg;
            nega_reg <= ~nega_reg;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            dvd_reg <= ra_reg;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.capture) begin
            gcd_reg <= ra_reg;
            inv_reg <= inv_next;
            has_reg <= (m_reg != '0) && (ra_reg == WIDTH'(1));
        end
    end

    assign status.rb_zero  = (rb_reg == '0);
    assign status.cnt_last = (cnt_reg == CNT_LAST);
    assign gcd_result      = gcd_reg;
    assign inverse         = inv_reg;
    assign has_inverse     = has_reg;

endmodule

### design/mie_ctrl.sv
// controller: sequences euclid rounds and owns the input and output handshakes
module mie_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mie_pkg::mie_status_t  status,
    output mie_pkg::mie_cmd_t     cmd
);
    import mie_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.rb_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.cnt_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.capture) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    // a waiting result is never overwritten
    a_capture_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (!valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_capture_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> m_tvalid)
        else $error("captured result not presented");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted beat did not start a round check");

    a_update_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> ($past(state_reg) == ST_DIV && $past(status.cnt_last)))
        else $error("update without a finished division");

endmodule

### design/modular_inverse_euclid.sv
// top level: modular inverse by the extended euclidean algorithm
//
// s_tdata carries one operand pair per beat: modulus in the low WIDTH bits,
// value above it. m_tdata returns gcd_result (low) and inverse (above it),
// with has_inverse on m_tuser. inverse is the coefficient of value reduced
// into 0 to modulus-1; it is the inverse when has_inverse is set.
//
// one item at a time: s_tready is high only while the block is idle. each
// euclid round is a check state, the bit-serial restoring divider, which
// also accumulates quotient times coefficient, and an update state. at 32
// bits the worst case is about 46 rounds, and a zero value goes straight
// from the check state to the finish state.
//
// results sit in an output register, so the next beat is accepted while a
// result waits; if the receiver stalls, the following item finishes its
// rounds and then holds until the register is taken.
// aresetn is synchronous, active low, and clears the controller and the
// output valid; no clearing pass is needed.
module modular_inverse_euclid (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mie_pkg::TDATA_W-1:0]   s_tdata,   // modulus, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mie_pkg::TDATA_W-1:0]   m_tdata,   // gcd_result, inverse
    output logic                          m_tuser    // has_inverse
);
    import mie_pkg::*;

    mie_cmd_t    cmd;
    mie_status_t status;
    word_t       gcd_result, inverse;
    logic        has_inverse;

    mie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mie_datapath u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .modulus     (s_tdata[WIDTH-1:0]),
        .value       (s_tdata[2*WIDTH-1:WIDTH]),
        .status      (status),
        .gcd_result  (gcd_result),
        .inverse     (inverse),
        .has_inverse (has_inverse)
    );

    assign m_tdata = TDATA_W'({inverse, gcd_result});
    assign m_tuser = has_inverse;

endmodule

### test/tb_top.sv
// testbench for modular_inverse_euclid: result scoreboard, stream drivers and stimulus
`timescale 1ns / 1ps

class inverse_scoreboard;

    typedef struct {
        mie_pkg::word_t gcd_val;
        mie_pkg::word_t inv_val;
        bit             has_inv;
    } inv_result_t;

    inv_result_t pending_results[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    // extended euclid with the coefficient of the value kept as magnitude plus sign
    function inv_result_t euclid_predict(mie_pkg::word_t m, mie_pkg::word_t b);
        logic [63:0] rem_a, rem_b, mag_a, mag_b, quo, rem_n, mag_n, red;
        bit          neg_a;
        inv_result_t res;
        rem_a = 64'(m);
        rem_b = 64'(b);
        mag_a = 64'd0;
        mag_b = 64'd1;
        neg_a = 1'b1;
        while (rem_b != 64'd0) begin
            quo   = rem_a / rem_b;
            rem_n = rem_a - quo * rem_b;
            mag_n = mag_a + quo * mag_b;
            rem_a = rem_b;
            rem_b = rem_n;
            mag_a = mag_b;
            mag_b = mag_n;
            neg_a = !neg_a;
        end
        res.gcd_val = rem_a[31:0];
        res.inv_val = '0;
        if (m != '0) begin
            red = mag_a % 64'(m);
            if (neg_a && red != 64'd0) begin
                res.inv_val = m - red[31:0];
            end else begin
                res.inv_val = red[31:0];
            end
        end
        res.has_inv = (m != '0) && (rem_a == 64'd1);
        return res;
    endfunction

    function void note_operands(mie_pkg::word_t m, mie_pkg::word_t b);
        pending_results = {pending_results, euclid_predict(m, b)};
    endfunction

    function void check_result(logic [mie_pkg::TDATA_W-1:0] data, logic flag);
        inv_result_t want;
        mie_pkg::word_t got_gcd, got_inv;
        got_gcd = data[31:0];
        got_inv = data[63:32];
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat gcd=%h inverse=%h has_inverse=%b",
                     $time, got_gcd, got_inv, flag);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (got_gcd !== want.gcd_val) begin
            $display("%0t: gcd_result expected %h actual %h", $time, want.gcd_val, got_gcd);
            mismatches++;
        end
        if (got_inv !== want.inv_val) begin
            $display("%0t: inverse expected %h actual %h", $time, want.inv_val, got_inv);
            mismatches++;
        end
        if (flag !== want.has_inv) begin
            $display("%0t: has_inverse expected %b actual %b", $time, want.has_inv, flag);
            mismatches++;
        end
    endfunction

endclass

module tb_top;

    import mie_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 1700;
    localparam longint CYCLE_LIMIT = 4000000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    bit                  no_gaps = 1'b0;
    longint              cycle_count = 0;
    inverse_scoreboard   sb;

    modular_inverse_euclid i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // hold a beat until taken; valid stays high into the next call
    task automatic send_pair(word_t m, word_t b);
        while (!no_gaps && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({b, m});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_operands(m, b);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
    endtask

    task automatic send_random_pair();
        word_t m, b, g;
        m = $urandom();
        b = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ;
            5: begin
                m = $urandom_range(1, 64);
                b = $urandom_range(0, 200);
            end
            6: begin
                m = $urandom_range(1, 1000);
                b = ($urandom_range(0, 1) != 0) ? '0 : m * $urandom_range(1, 5);
            end
            7: begin
                m = $urandom_range(1, 100000);
            end
            8: begin
                // force a shared factor so gcd is not 1
                g = $urandom_range(2, 5000);
                m = g * $urandom_range(1, 500000);
                b = g * $urandom_range(0, 500000);
            end
            default: begin
                m = {1'b1, m[30:0]};
                b = {1'b1, b[30:0]};
            end
        endcase
        if (m == '0) m = 32'd1;
        send_pair(m, b);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (aresetn) m_tready <= no_gaps || ($urandom_range(0, 99) >= 24);
        end
    end

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pair(32'd1, 32'd0);
        send_pair(32'd1, 32'd1);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'd12, 32'd0);
        send_pair(32'd7, 32'd3);
        send_pair(32'd6, 32'd4);
        send_pair(32'd5, 32'd13);
        send_pair(32'd9, 32'd9);
        send_pair(32'd10, 32'd30);
        send_pair(32'd2, 32'd1);
        // consecutive fibonacci numbers give the most rounds
        send_pair(32'd2971215073, 32'd1836311903);
        send_pair(32'd1836311903, 32'd2971215073);
        send_pair(32'h8000_0000, 32'd3);
        send_pair(32'h8000_0000, 32'h4000_0000);
        send_pair(32'd4294967291, 32'd2);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        send_pair(32'hAAAA_AAAB, 32'h5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_gaps = (i >= 120 && i < 200);
            if (i == 260) wait_for_drain();
            send_random_pair();
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### files.f
design/mie_pkg.sv
design/mie_datapath.sv
design/mie_ctrl.sv
design/modular_inverse_euclid.sv
test/tb_top.sv
